/* rtl/core/lcdtb_pkg.sv */
// Package: shared types and constants for the LCD timing / background renderer.
package lcdtb_pkg;

    localparam int VRAM_DEPTH  = 8192;
    localparam int VRAM_AW     = $clog2(VRAM_DEPTH);
    localparam int LINE_PIXELS = 160;
    localparam int NUM_GROUPS  = (LINE_PIXELS + 7) / 8;
    localparam int GROUP_W     = 5;

    localparam logic [9:0] HBLANK_CYC = 10'd204;
    localparam logic [9:0] VBLANK_CYC = 10'd456;
    localparam logic [9:0] OAM_CYC    = 10'd80;
    localparam logic [9:0] VRAM_CYC   = 10'd172;
    localparam logic [7:0] LAST_LINE  = 8'd153;
    localparam logic [7:0] VBL_LINE   = 8'd144;
    localparam logic [12:0] MAP0_BASE = 13'h1800;
    localparam logic [12:0] MAP1_BASE = 13'h1C00;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_VRAM   = 2'd3
    } lcd_mode_t;

    typedef enum logic [2:0] {
        REG_SCROLL_X = 3'd0,
        REG_SCROLL_Y = 3'd1,
        REG_PALETTE  = 3'd2,
        REG_BG_EN    = 3'd3,
        REG_MAP_SEL  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_STATUS, BK_MAP, BK_LO, BK_HI, BK_PIX, BK_OUT
    } back_state_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  cycles;
        logic [12:0] vram_addr;
        logic [7:0]  vram_data;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  mode;
        logic [7:0]  line;
        logic        vblank_start;
        logic [15:0] shades;
        logic [4:0]  group;
        logic        last;
    } out_item_t;

    // Job handed from front to back through the queue.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic       vblank_start;
        logic       render;
    } job_t;

    typedef struct packed {
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic [7:0] palette;
        logic       bg_enable;
        logic       map_select;
    } cfg_t;

endpackage

/* rtl/core/lcdtb_front.sv */
// Front: accepts items, runs mode timing, writes video memory, queues jobs.
module lcdtb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcdtb_pkg::in_item_t s_data,
    input  logic                bg_enable,
    input  logic                back_idle,
    output logic                job_push,
    output lcdtb_pkg::job_t     job,
    input  logic                job_full,
    output logic                wr_en,
    output logic [12:0]         wr_addr,
    output logic [7:0]          wr_data
);
    logic [9:0] clk_reg, clk_next;
    lcdtb_pkg::lcd_mode_t mode_reg, mode_next;
    logic [7:0] line_reg, line_next;
    logic vb, rend;
    logic [9:0] sum;
    logic acc;

    // A tick needs a queue slot; a write waits until no line fetch is pending,
    // so it never lands ahead of a render that an earlier tick asked for.
    assign s_ready = s_data.op ? back_idle : ~job_full;
    assign acc     = s_valid & s_ready;
    assign sum     = clk_reg + {2'b0, s_data.cycles};

    always_comb begin
        clk_next  = sum;
        mode_next = mode_reg;
        line_next = line_reg;
        vb        = 1'b0;
        rend      = 1'b0;
        case (mode_reg)
            lcdtb_pkg::MODE_HBLANK: if (sum >= lcdtb_pkg::HBLANK_CYC) begin
                clk_next  = '0;
                line_next = line_reg + 8'd1;
                if (line_next == lcdtb_pkg::VBL_LINE) begin
                    mode_next = lcdtb_pkg::MODE_VBLANK;
                    vb        = 1'b1;
                end else begin
                    mode_next = lcdtb_pkg::MODE_OAM;
                end
            end
            lcdtb_pkg::MODE_VBLANK: if (sum >= lcdtb_pkg::VBLANK_CYC) begin
                clk_next  = '0;
                line_next = line_reg + 8'd1;
                if (line_next > lcdtb_pkg::LAST_LINE) begin
                    line_next = '0;
                    mode_next = lcdtb_pkg::MODE_OAM;
                end
            end
            lcdtb_pkg::MODE_OAM: if (sum >= lcdtb_pkg::OAM_CYC) begin
                clk_next  = '0;
                mode_next = lcdtb_pkg::MODE_VRAM;
            end
            default: if (sum >= lcdtb_pkg::VRAM_CYC) begin
                clk_next  = '0;
                mode_next = lcdtb_pkg::MODE_HBLANK;
                rend      = bg_enable;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_reg  <= '0;
            mode_reg <= lcdtb_pkg::MODE_OAM;
            line_reg <= '0;
        end else if (acc && !s_data.op) begin
            clk_reg  <= clk_next;
            mode_reg <= mode_next;
            line_reg <= line_next;
        end
    end

    assign job_push = acc & ~s_data.op;
    assign job      = '{mode: mode_next, line: line_next, vblank_start: vb, render: rend};
    assign wr_en    = acc & s_data.op;
    assign wr_addr  = s_data.vram_addr;
    assign wr_data  = s_data.vram_data;
endmodule

/* rtl/core/lcdtb_queue.sv */
// Two-entry job queue between front and back.
module lcdtb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lcdtb_pkg::job_t din,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output lcdtb_pkg::job_t dout
);
    lcdtb_pkg::job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* rtl/core/lcdtb_back.sv */
// Back: emits status, then for a render job fetches the scanline one pixel per step from VRAM.
module lcdtb_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcdtb_pkg::cfg_t      cfg,
    input  logic                 job_empty,
    input  lcdtb_pkg::job_t      job,
    output logic                 job_pop,
    output logic                 idle,
    input  logic                 wr_en,
    input  logic [12:0]          wr_addr,
    input  logic [7:0]           wr_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lcdtb_pkg::out_item_t m_data
);
    logic [7:0] vmem [lcdtb_pkg::VRAM_DEPTH];
    logic [7:0] rd_reg;
    logic [12:0] rd_addr;
    logic rd_en;

    lcdtb_pkg::back_state_t st_reg, st_next;
    lcdtb_pkg::job_t job_reg;
    logic [7:0] pix_reg;     // pixel index within line
    logic [7:0] lo_reg;
    logic [15:0] sh_reg;
    lcdtb_pkg::out_item_t out_reg;
    logic ov_reg;

    logic [7:0] row, px;
    logic [2:0] bitn;
    logic [1:0] ci, shade;
    logic [12:0] mapb, tbase;
    logic pix_last, grp_last;

    assign row   = job_reg.line + cfg.scroll_y;
    assign px    = cfg.scroll_x + pix_reg;
    assign mapb  = cfg.map_select ? lcdtb_pkg::MAP1_BASE : lcdtb_pkg::MAP0_BASE;
    assign tbase = {1'b0, rd_reg, row[2:0], 1'b0};
    assign bitn  = 3'd7 - px[2:0];
    assign ci    = {rd_reg[bitn], lo_reg[bitn]};
    assign shade = (pix_reg < 8'(lcdtb_pkg::LINE_PIXELS)) ? cfg.palette[{ci, 1'b0} +: 2] : 2'd0;
    assign grp_last = pix_reg[7:3] == 5'(lcdtb_pkg::NUM_GROUPS - 1);
    assign pix_last = pix_reg[2:0] == 3'd7;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = tbase;
        case (st_reg)
            lcdtb_pkg::BK_MAP: begin
                rd_en   = 1'b1;
                rd_addr = mapb + {3'b0, row[7:3], 5'b0} + {8'b0, px[7:3]};
            end
            lcdtb_pkg::BK_LO: begin
                rd_en   = 1'b1;
                rd_addr = tbase;
            end
            lcdtb_pkg::BK_HI: begin
                rd_en   = 1'b1;
                rd_addr = {1'b0, lo_reg, row[2:0], 1'b1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) vmem[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= vmem[rd_addr];
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            lcdtb_pkg::BK_IDLE:   if (!job_empty) st_next = lcdtb_pkg::BK_STATUS;
            lcdtb_pkg::BK_STATUS: if (!ov_reg)
                st_next = job_reg.render ? lcdtb_pkg::BK_MAP : lcdtb_pkg::BK_IDLE;
            lcdtb_pkg::BK_MAP:    st_next = lcdtb_pkg::BK_LO;
            lcdtb_pkg::BK_LO:     st_next = lcdtb_pkg::BK_HI;
            lcdtb_pkg::BK_HI:     st_next = lcdtb_pkg::BK_PIX;
            lcdtb_pkg::BK_PIX:    st_next = pix_last ? lcdtb_pkg::BK_OUT : lcdtb_pkg::BK_MAP;
            lcdtb_pkg::BK_OUT:    if (!ov_reg)
                st_next = grp_last ? lcdtb_pkg::BK_IDLE : lcdtb_pkg::BK_MAP;
            default:              st_next = lcdtb_pkg::BK_IDLE;
        endcase
    end

    assign job_pop = (st_reg == lcdtb_pkg::BK_IDLE) && !job_empty;
    assign idle    = st_reg == lcdtb_pkg::BK_IDLE;
    assign m_valid = ov_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= lcdtb_pkg::BK_IDLE;
            ov_reg  <= 1'b0;
            pix_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (m_ready) ov_reg <= 1'b0;
            case (st_reg)
                lcdtb_pkg::BK_IDLE: begin
                    job_reg <= job;
                    pix_reg <= '0;
                end
                lcdtb_pkg::BK_STATUS: if (!ov_reg) begin
                    ov_reg  <= 1'b1;
                    out_reg <= '{kind: 1'b0, mode: job_reg.mode, line: job_reg.line,
                                 vblank_start: job_reg.vblank_start, shades: 16'd0,
                                 group: 5'd0, last: ~job_reg.render};
                end
                lcdtb_pkg::BK_HI:  lo_reg <= rd_reg;
                lcdtb_pkg::BK_LO:  lo_reg <= rd_reg;
                lcdtb_pkg::BK_PIX: begin
                    sh_reg <= {sh_reg[13:0], shade};
                    if (!pix_last) pix_reg <= pix_reg + 8'd1;
                end
                lcdtb_pkg::BK_OUT: if (!ov_reg) begin
                    ov_reg  <= 1'b1;
                    out_reg <= '{kind: 1'b1, mode: job_reg.mode, line: job_reg.line,
                                 vblank_start: 1'b0, shades: sh_reg,
                                 group: pix_reg[7:3], last: grp_last};
                    pix_reg <= pix_reg + 8'd1;
                end
                default: ;
            endcase
        end
    end
endmodule

/* rtl/core/lcd_timing_tile_background.sv */
// Top level: LCD mode timing with background scanline renderer.
//
// s_ channel: one item per transfer. op=0 is a tick that advances the mode
// clock by cycles; op=1 writes vram_data at vram_addr and yields no result.
// m_ channel: each tick yields a status result (kind=0). When the tick ends
// mode 3 with the background on, 20 pixel-group results (kind=1) follow,
// group 0 upward; last marks the final result of the tick.
// cfg channel: cfg_index selects scroll_x, scroll_y, bg_palette, bg_enable
// or bg_map_select; write only while idle.
// Timing: the front takes a tick and hands it to a two-deep job queue. The
// back pops it in BK_IDLE, goes to BK_STATUS and loads the status into its
// result register, which drives m_valid. For each pixel of a rendered line
// the back reads map, low plane and high plane on the VRAM read port, then
// shifts, plus an output step per group. A write waits until the queue is empty
// and the back is idle, so it never overtakes a pending line fetch.
// Reset: mode 2, line 0, clock 0, registers 0; video memory is not cleared.
// A stalled m_ready holds the result register; the back waits, the queue
// fills and s_ready drops for ticks once two jobs are pending, and for
// writes as long as any job is pending or in the back.
module lcd_timing_tile_background (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lcdtb_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lcdtb_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data
);
    lcdtb_pkg::cfg_t cfg_reg;
    lcdtb_pkg::job_t job_in, job_out;
    logic push, pop, full, empty, wr_en;
    logic bk_idle, back_idle;
    logic [12:0] wr_addr;
    logic [7:0] wr_data;

    assign cfg_ready = 1'b1;
    assign back_idle = empty & bk_idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                lcdtb_pkg::REG_SCROLL_X: cfg_reg.scroll_x   <= cfg_data;
                lcdtb_pkg::REG_SCROLL_Y: cfg_reg.scroll_y   <= cfg_data;
                lcdtb_pkg::REG_PALETTE:  cfg_reg.palette    <= cfg_data;
                lcdtb_pkg::REG_BG_EN:    cfg_reg.bg_enable  <= cfg_data[0];
                lcdtb_pkg::REG_MAP_SEL:  cfg_reg.map_select <= cfg_data[0];
                default: ;
            endcase
        end
    end

    lcdtb_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .bg_enable(cfg_reg.bg_enable), .back_idle(back_idle),
        .job_push(push), .job(job_in), .job_full(full), .wr_en(wr_en),
        .wr_addr(wr_addr), .wr_data(wr_data)
    );

    lcdtb_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .din(job_in), .full(full),
        .pop(pop), .empty(empty), .dout(job_out)
    );

    lcdtb_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .job_empty(empty),
        .job(job_out), .job_pop(pop), .idle(bk_idle), .wr_en(wr_en),
        .wr_addr(wr_addr), .wr_data(wr_data), .m_valid(m_valid),
        .m_ready(m_ready), .m_data(m_data)
    );
endmodule

/* rtl/core/lcdtb_checker.sv */
// Port-level checker for the LCD timing block, with bind.
module lcdtb_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input lcdtb_pkg::out_item_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.kind |-> m_data.shades == 16'd0 && m_data.group == 5'd0)
        else $error("status carries pixel data");
    a_vb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.vblank_start |-> m_data.mode == 2'd1 && m_data.line == 8'd144)
        else $error("bad vblank start");
    a_grp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind |-> m_data.mode == 2'd0 && m_data.group < 5'd20)
        else $error("bad pixel group");
endmodule

bind lcd_timing_tile_background lcdtb_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
